>>> src/sfpg_pkg.sv
// shared types and constants for the starfield pixel generator
package sfpg_pkg;

    localparam int ROM_DEPTH   = 4096;
    localparam int ROM_AW      = 12;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [9:0] STAR_COLOR_BASE = 10'h378;
    localparam logic [4:0] MATCH_FLIP      = 5'h1e;

    localparam logic [8:0] WIN_X_MIN = 9'd64;
    localparam logic [8:0] WIN_X_MAX = 9'd447;
    localparam logic [7:0] WIN_Y_MIN = 8'd16;
    localparam logic [7:0] WIN_Y_MAX = 8'd239;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [2:0] {
        MODE_PIXEL    = 3'd0,
        MODE_HSTEP    = 3'd1,
        MODE_VSTEP    = 3'd2,
        MODE_ENABLE   = 3'd3,
        MODE_ROM_LOAD = 3'd4
    } mode_t;

    // work handed from the front end to the back end
    typedef struct packed {
        logic       load;
        logic       vis_test;
        logic [4:0] key;
        logic [7:0] rom_data;
    } entry_t;

endpackage

>>> src/starfield_pixel_generator.sv
// top level of the starfield pixel generator
//
// channel  dir  tdata (low bit first)                                    tuser
// s_axis   in   pix_x[8:0] pix_y[16:9] enable_bit[17] rom_address[29:18]  mode[2:0]
//                rom_byte[37:30], zero to bit 39
// m_axis   out  star_visible[0] color_index[10:1], zero to bit 15        -
//
// one item per cycle sustained while m_axis_tready stays high; m_axis_tvalid comes from the output register
// stages: star rom read register at the transfer edge, queue slot, output register
// reset clears scroll state (carry is set to one), latch and queue; the star rom holds no reset value
// a stalled output fills the queue, then s_axis_tready drops
module starfield_pixel_generator #(
    parameter int QUEUE_DEPTH = sfpg_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sfpg_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // pix_x, pix_y, enable_bit, rom_address, rom_byte
    input  logic [2:0]                      s_axis_tuser,  // mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sfpg_pkg::OUT_DATA_W-1:0] m_axis_tdata   // star_visible, color_index
);

    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    logic                 push;
    sfpg_pkg::entry_t     push_entry;
    logic                 pop;
    logic                 head_valid;
    sfpg_pkg::entry_t     head_entry;
    logic [LEVEL_W-1:0]   level;
    logic                 star_visible;
    logic [9:0]           color_index;

    sfpg_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LEVEL_W     (LEVEL_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .mode        (s_axis_tuser),
        .pix_x       (s_axis_tdata[8:0]),
        .pix_y       (s_axis_tdata[16:9]),
        .enable_bit  (s_axis_tdata[17]),
        .rom_address (s_axis_tdata[29:18]),
        .rom_byte    (s_axis_tdata[37:30]),
        .queue_level (level),
        .push        (push),
        .push_entry  (push_entry)
    );

    sfpg_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LEVEL_W     (LEVEL_W)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_entry  (push_entry),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .level       (level)
    );

    sfpg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .star_visible (star_visible),
        .color_index  (color_index)
    );

    assign m_axis_tdata = {5'b00000, color_index, star_visible};

endmodule

>>> src/sfpg_front.sv
// front end: scroll state, star rom, address generation and pixel classification
module sfpg_front #(
    parameter int QUEUE_DEPTH = sfpg_pkg::QUEUE_DEPTH,
    parameter int LEVEL_W     = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  logic [8:0]            pix_x,
    input  logic [7:0]            pix_y,
    input  logic                  enable_bit,
    input  logic [11:0]           rom_address,
    input  logic [7:0]            rom_byte,
    input  logic [LEVEL_W-1:0]    queue_level,
    output logic                  push,
    output sfpg_pkg::entry_t      push_entry
);

    logic [7:0] rom_mem [sfpg_pkg::ROM_DEPTH];
    logic [7:0] rom_q;

    logic [8:0] hscroll_reg, hscroll_next;
    logic [7:0] vscroll_reg, vscroll_next;
    logic       carry_reg, carry_next;
    logic       enable_reg, enable_next;
    logic [8:0] prev_hsum_reg, prev_hsum_next;

    logic       stage_valid_reg;
    logic       stage_load_reg;
    logic       stage_vis_test_reg;
    logic [4:0] stage_key_reg;

    logic                accept;
    sfpg_pkg::mode_t     mode_code;
    logic [7:0]          hc;
    logic [8:0]          hsum;
    logic [7:0]          vsum;
    logic [8:0]          pre_sum;
    logic [8:0]          pre_h;
    logic [8:0]          prev_eff;
    logic [8:0]          fetch_h;
    logic                in_window;
    logic                preload;
    logic                tested;
    logic                fetch_hit;
    logic                load;
    logic                rom_wr;
    logic [sfpg_pkg::ROM_AW-1:0] rd_addr;

    assign in_ready = ((LEVEL_W + 1)'(queue_level) + (LEVEL_W + 1)'(stage_valid_reg))
                      < (LEVEL_W + 1)'(QUEUE_DEPTH);
    assign accept    = in_valid && in_ready;
    assign mode_code = sfpg_pkg::mode_t'(mode);

    // pixel classification
    assign hc        = hscroll_reg[7:0];
    assign hsum      = {1'b0, hc} + {1'b0, pix_x[7:0]};
    assign vsum      = vscroll_reg + pix_y;
    assign pre_sum   = {1'b0, hc} + 9'd64;
    assign pre_h     = {pre_sum[8:5], 5'b00000};
    assign in_window = enable_reg
                       && (pix_x >= sfpg_pkg::WIN_X_MIN) && (pix_x <= sfpg_pkg::WIN_X_MAX)
                       && (pix_y >= sfpg_pkg::WIN_Y_MIN) && (pix_y <= sfpg_pkg::WIN_Y_MAX);
    assign preload   = in_window && (pix_x == sfpg_pkg::WIN_X_MIN);
    assign prev_eff  = preload ? ({1'b0, hc} + 9'd63) : prev_hsum_reg;
    assign tested    = in_window && (vsum[2] ^ pix_x[5]) && !(vsum[1] | hsum[2]);
    assign fetch_hit = tested && (prev_eff[4:0] == 5'h1f);
    assign load      = (mode_code == sfpg_pkg::MODE_PIXEL) && (preload || fetch_hit);
    assign fetch_h   = fetch_hit ? hsum : pre_h;
    assign rd_addr   = {vsum, carry_reg ^ fetch_h[8], fetch_h[7:5]};
    assign rom_wr    = accept && (mode_code == sfpg_pkg::MODE_ROM_LOAD);

    always_comb
    begin
        hscroll_next   = hscroll_reg;
        vscroll_next   = vscroll_reg;
        carry_next     = carry_reg;
        enable_next    = enable_reg;
        prev_hsum_next = prev_hsum_reg;
        if (accept)
        begin
            unique case (mode_code)
                sfpg_pkg::MODE_PIXEL:
                begin
                    prev_hsum_next = hsum;
                end
                sfpg_pkg::MODE_HSTEP:
                begin
                    hscroll_next = hscroll_reg + 9'd1;
                    if (hscroll_next[8] && !hscroll_reg[8])
                    begin
                        carry_next = !carry_reg;
                    end
                end
                sfpg_pkg::MODE_VSTEP:
                begin
                    vscroll_next = vscroll_reg + 8'd1;
                end
                sfpg_pkg::MODE_ENABLE:
                begin
                    if (enable_bit != enable_reg)
                    begin
                        enable_next  = enable_bit;
                        carry_next   = 1'b1;
                        hscroll_next = '0;
                        vscroll_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hscroll_reg     <= '0;
            vscroll_reg     <= '0;
            carry_reg       <= 1'b1;
            enable_reg      <= 1'b0;
            prev_hsum_reg   <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            hscroll_reg     <= hscroll_next;
            vscroll_reg     <= vscroll_next;
            carry_reg       <= carry_next;
            enable_reg      <= enable_next;
            prev_hsum_reg   <= prev_hsum_next;
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_load_reg     <= load;
            stage_vis_test_reg <= (mode_code == sfpg_pkg::MODE_PIXEL) && tested;
            stage_key_reg      <= hsum[4:0] ^ sfpg_pkg::MATCH_FLIP;
        end
    end

    // star rom
    always_ff @(posedge clk)
    begin
        if (rom_wr)
        begin
            rom_mem[rom_address] <= rom_byte;
        end
        if (accept)
        begin
            rom_q <= rom_mem[rd_addr];
        end
    end

    assign push                = stage_valid_reg;
    assign push_entry.load     = stage_load_reg;
    assign push_entry.vis_test = stage_vis_test_reg;
    assign push_entry.key      = stage_key_reg;
    assign push_entry.rom_data = rom_q;

endmodule

>>> src/sfpg_queue.sv
// short queue between the front end and the back end
module sfpg_queue #(
    parameter int QUEUE_DEPTH = sfpg_pkg::QUEUE_DEPTH,
    parameter int LEVEL_W     = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sfpg_pkg::entry_t      push_entry,
    input  logic                  pop,
    output logic                  head_valid,
    output sfpg_pkg::entry_t      head_entry,
    output logic [LEVEL_W-1:0]    level
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    sfpg_pkg::entry_t    slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = (level_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (level_reg < LEVEL_W'(QUEUE_DEPTH)))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (level_reg != '0))
        else $error("pop from empty queue");

endmodule

>>> src/sfpg_back.sv
// back end: data latch, star match and output register
module sfpg_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  sfpg_pkg::entry_t      head_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  star_visible,
    output logic [9:0]            color_index
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] latch_reg, latch_next;
    logic       vis_reg, vis_next;
    logic [9:0] color_reg, color_next;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        latch_next     = latch_reg;
        vis_next       = vis_reg;
        color_next     = color_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next = 1'b1;
            latch_next     = head_entry.load ? head_entry.rom_data : latch_reg;
            vis_next       = head_entry.vis_test && (latch_next[4:0] == head_entry.key);
            color_next     = vis_next ? (sfpg_pkg::STAR_COLOR_BASE | {7'b0, latch_next[7:5]})
                                      : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            latch_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            latch_reg     <= latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vis_reg   <= vis_next;
        color_reg <= color_next;
    end

    assign out_valid    = out_valid_reg;
    assign star_visible = vis_reg;
    assign color_index  = color_reg;

    a_color_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (vis_reg == (color_reg != 10'd0)))
        else $error("color and visibility disagree");

endmodule

>>> bench/starfield_pixel_checker.sv
// checker for the starfield pixel generator: predicts every result and compares it
module starfield_pixel_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [sfpg_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // pix_x, pix_y, enable_bit, rom_address, rom_byte
    input  logic [2:0]                      s_axis_tuser,   // mode
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [sfpg_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // star_visible, color_index
    output int                              errors,
    output int                              pending,
    output int                              results,
    output int                              stars
);

    localparam logic [8:0] X_FIRST   = 9'd64;
    localparam logic [8:0] X_LAST    = 9'd447;
    localparam logic [7:0] Y_FIRST   = 8'd16;
    localparam logic [7:0] Y_LAST    = 8'd239;
    localparam logic [9:0] STAR_BASE = 10'h378;

    typedef struct packed {
        logic       visible;
        logic [9:0] color;
    } star_pixel_t;

    star_pixel_t expected_pixels[$];
    star_pixel_t want;
    star_pixel_t got;

    logic [7:0] star_rom [0:4095];
    logic [7:0] latch_q;
    logic [8:0] prev_sum;
    logic [8:0] h_scroll;
    logic [7:0] v_scroll;
    logic       carry;
    logic       stars_on;

    function automatic logic [7:0] rom_lookup(input logic [7:0] vsum, input logic [8:0] hsum);
        return star_rom[{vsum, carry ^ hsum[8], hsum[7:5]}];
    endfunction

    task automatic advance_starfield(
        input  logic [2:0]  mode,
        input  logic [8:0]  x,
        input  logic [7:0]  y,
        input  logic        en,
        input  logic [11:0] addr,
        input  logic [7:0]  value,
        output star_pixel_t res
    );
        logic [7:0] hc;
        logic [7:0] vsum;
        logic [8:0] nxt;
        logic [8:0] hsum;
        logic [8:0] prev;
        logic [8:0] left_sum;
        logic       in_window;
        res = '0;
        case (mode)
            sfpg_pkg::MODE_HSTEP:
            begin
                nxt = h_scroll + 9'd1;
                if (nxt[8] && !h_scroll[8])
                begin
                    carry = ~carry;
                end
                h_scroll = nxt;
            end
            sfpg_pkg::MODE_VSTEP:
            begin
                v_scroll = v_scroll + 8'd1;
            end
            sfpg_pkg::MODE_ENABLE:
            begin
                if (stars_on != en)
                begin
                    stars_on = en;
                    carry    = 1'b1;
                    h_scroll = '0;
                    v_scroll = '0;
                end
            end
            sfpg_pkg::MODE_ROM_LOAD:
            begin
                star_rom[addr] = value;
            end
            sfpg_pkg::MODE_PIXEL:
            begin
                hc        = h_scroll[7:0];
                vsum      = v_scroll + y;
                in_window = stars_on && x >= X_FIRST && x <= X_LAST
                            && y >= Y_FIRST && y <= Y_LAST;
                // preload at the left window edge
                if (in_window && x == X_FIRST)
                begin
                    left_sum      = {1'b0, hc} + 9'd64;
                    left_sum[4:0] = 5'd0;
                    latch_q       = rom_lookup(vsum, left_sum);
                    prev_sum      = {1'b0, hc} + 9'd63;
                end
                prev     = prev_sum;
                hsum     = {1'b0, hc} + {1'b0, x[7:0]};
                prev_sum = hsum;
                if (in_window && (vsum[2] ^ x[5]) && !(vsum[1] | hsum[2]))
                begin
                    if (prev[4:0] == 5'h1f)
                    begin
                        latch_q = rom_lookup(vsum, hsum);
                    end
                    if ((latch_q[4:0] ^ hsum[4:0]) == 5'h1e)
                    begin
                        res.visible = 1'b1;
                        res.color   = STAR_BASE | {7'd0, latch_q[7:5]};
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_q  = '0;
            prev_sum = '0;
            h_scroll = '0;
            v_scroll = '0;
            carry    = 1'b1;
            stars_on = 1'b0;
            expected_pixels.delete();
            errors   = 0;
            pending  = 0;
            results  = 0;
            stars    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results++;
                got.visible = m_axis_tdata[0];
                got.color   = m_axis_tdata[10:1];
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    $error("result transfer with nothing expected: tdata %h", m_axis_tdata);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.visible)
                    begin
                        stars++;
                    end
                    if (got.visible !== want.visible)
                    begin
                        errors++;
                        $error("star_visible: expected %0d, got %0d", want.visible, got.visible);
                    end
                    if (got.color !== want.color)
                    begin
                        errors++;
                        $error("color_index: expected %h, got %h", want.color, got.color);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_starfield(s_axis_tuser, s_axis_tdata[8:0], s_axis_tdata[16:9],
                                  s_axis_tdata[17], s_axis_tdata[29:18], s_axis_tdata[37:30],
                                  want);
                expected_pixels.push_back(want);
            end
            pending = expected_pixels.size();
        end
    end

endmodule

>>> bench/starfield_pixel_generator_tb.sv
// testbench top for the starfield pixel generator: stimulus, flow control and verdict
module starfield_pixel_generator_tb;

    localparam int ITEM_TARGET = 900;
    localparam int CALM_START  = 780;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [sfpg_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // pix_x, pix_y, enable_bit, rom_address, rom_byte
    logic [2:0]                      s_axis_tuser;   // mode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [sfpg_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // star_visible, color_index

    int fail_count;
    int pending_results;
    int result_count;
    int star_count;

    bit         s_fire_q;
    bit         rom_written [0:4095];
    logic [7:0] ready_rows[$];
    logic [7:0] vscroll_m;
    bit         en_m;
    int         items_sent;
    bit         calm;
    bit         send_quiet;
    bit         burst;
    bit         hold_request;
    int         long_scrolls;
    int         holds;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    starfield_pixel_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    starfield_pixel_checker pixel_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (fail_count),
        .pending       (pending_results),
        .results       (result_count),
        .stars         (star_count)
    );

    always @(posedge clk)
    begin
        s_fire_q <= s_axis_tvalid && s_axis_tready;
    end

    function automatic bit row_loaded(input logic [7:0] row);
        for (int i = 0; i < 16; i++)
        begin
            if (!rom_written[{row, i[3:0]}])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // a pixel inside the active window must only address fully loaded rom rows
    function automatic bit reads_unloaded(input logic [8:0] x, input logic [7:0] y);
        logic [7:0] row;
        row = vscroll_m + y;
        return en_m && x >= 9'd64 && x <= 9'd447 && y >= 8'd16 && y <= 8'd239
               && !row_loaded(row);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(
        input logic [2:0]  mode,
        input logic [8:0]  x,
        input logic [7:0]  y,
        input logic        en,
        input logic [11:0] addr,
        input logic [7:0]  value
    );
        if (!calm && !burst && !send_quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_axis_tdata  <= {2'b00, value, addr, en, y, x};
        s_axis_tuser  <= mode;
        s_axis_tvalid <= 1'b1;
        do @(negedge clk); while (!s_fire_q);
        case (mode)
            sfpg_pkg::MODE_VSTEP:
            begin
                vscroll_m = vscroll_m + 8'd1;
            end
            sfpg_pkg::MODE_ENABLE:
            begin
                if (en != en_m)
                begin
                    en_m      = en;
                    vscroll_m = '0;
                end
            end
            sfpg_pkg::MODE_ROM_LOAD:
            begin
                rom_written[addr] = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (mode <= sfpg_pkg::MODE_ROM_LOAD)
        begin
            items_sent++;
        end
    endtask

    task automatic send_op(input logic [2:0] mode);
        send_item(mode, 9'($urandom), 8'($urandom), 1'($urandom), 12'($urandom),
                  8'($urandom));
    endtask

    task automatic send_pixel(input logic [8:0] x, input logic [7:0] y);
        send_item(sfpg_pkg::MODE_PIXEL, x, y, 1'($urandom), 12'($urandom), 8'($urandom));
    endtask

    task automatic send_enable(input logic en);
        send_item(sfpg_pkg::MODE_ENABLE, 9'($urandom), 8'($urandom), en, 12'($urandom),
                  8'($urandom));
    endtask

    task automatic send_load(input logic [11:0] addr, input logic [7:0] value);
        send_item(sfpg_pkg::MODE_ROM_LOAD, 9'($urandom), 8'($urandom), 1'($urandom), addr,
                  value);
    endtask

    task automatic load_row(input logic [7:0] row);
        for (int i = 0; i < 16; i++)
        begin
            send_load({row, i[3:0]}, 8'($urandom));
        end
        ready_rows.push_back(row);
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending_results != 0);
    endtask

    // one scan line segment in raster order over a loaded star row
    task automatic scan_run(input int len_max);
        int         len;
        int         x0;
        bit         found;
        logic [7:0] y;
        logic [7:0] row;
        if (!en_m)
        begin
            send_enable(1'b1);
        end
        found = 1'b0;
        if (ready_rows.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            row   = ready_rows[$urandom_range(0, ready_rows.size() - 1)];
            y     = row - vscroll_m;
            found = (y >= 8'd16 && y <= 8'd239);
        end
        if (!found)
        begin
            case ($urandom_range(0, 5))
                0: y = 8'd16;
                1: y = 8'd239;
                default: y = 8'($urandom_range(16, 239));
            endcase
            row = vscroll_m + y;
            if (!row_loaded(row))
            begin
                load_row(row);
            end
        end
        len = $urandom_range(8, len_max);
        case ($urandom_range(0, 7))
            0, 1, 2, 3: x0 = 64;
            4: x0 = 448 - len;
            default: x0 = $urandom_range(64, 448 - len);
        endcase
        for (int i = 0; i < len; i++)
        begin
            send_pixel(9'(x0 + i), y);
        end
    endtask

    task automatic send_noise(input int count);
        logic [2:0] mode;
        logic [8:0] x;
        logic [7:0] y;
        int         tries;
        for (int i = 0; i < count; i++)
        begin
            mode = 3'($urandom_range(0, 7));
            if (mode == sfpg_pkg::MODE_PIXEL)
            begin
                x     = 9'($urandom);
                y     = 8'($urandom);
                tries = 0;
                while (reads_unloaded(x, y) && tries < 8)
                begin
                    x = 9'($urandom);
                    y = 8'($urandom);
                    tries++;
                end
                if (reads_unloaded(x, y))
                begin
                    x = 9'($urandom_range(0, 63));
                end
                send_pixel(x, y);
            end
            else
            begin
                send_op(mode);
            end
        end
    endtask

    initial
    begin
        #3_200_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int  span;
        bit  quiet;
        span          = 0;
        quiet         = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                quiet = ($urandom_range(0, 2) == 0);
                span  = 100;
            end
            span--;
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (60) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (!calm && !quiet && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = sfpg_pkg::MODE_PIXEL;
        vscroll_m     = '0;
        en_m          = 1'b0;
        items_sent    = 0;
        calm          = 1'b0;
        send_quiet    = 1'b0;
        burst         = 1'b0;
        hold_request  = 1'b0;
        long_scrolls  = 0;
        holds         = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, ignored modes, enable writes, window borders
        send_pixel(9'd0, 8'd0);
        send_pixel(9'd511, 8'd255);
        send_enable(1'b0);
        send_load(12'h000, 8'h00);
        send_load(12'hfff, 8'hff);
        send_op(3'd5);
        send_op(3'd6);
        send_op(3'd7);
        send_enable(1'b1);
        send_op(sfpg_pkg::MODE_HSTEP);
        send_op(sfpg_pkg::MODE_VSTEP);
        send_pixel(9'd63, 8'd100);
        send_pixel(9'd448, 8'd100);
        send_pixel(9'd200, 8'd15);
        send_pixel(9'd200, 8'd240);
        send_pixel(9'd511, 8'd255);
        send_pixel(9'd0, 8'd0);
        send_enable(1'b0);
        send_enable(1'b1);
        send_op(sfpg_pkg::MODE_HSTEP);
        wait_results_done();

        // long output hold while the sender keeps offering transfers
        hold_request = 1'b1;
        burst        = 1'b1;
        scan_run(48);
        burst        = 1'b0;
        holds++;
        wait_results_done();

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= CALM_START)
            begin
                calm = 1'b1;
            end
            send_quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                12, 13:
                begin
                    send_noise($urandom_range(1, 10));
                end
                14:
                begin
                    repeat ($urandom_range(1, 20)) send_op(sfpg_pkg::MODE_HSTEP);
                end
                15:
                begin
                    repeat ($urandom_range(1, 6)) send_op(sfpg_pkg::MODE_VSTEP);
                end
                16:
                begin
                    send_enable(1'b0);
                    repeat ($urandom_range(1, 12)) send_pixel(9'($urandom), 8'($urandom));
                    send_enable(1'b1);
                end
                17:
                begin
                    if (long_scrolls < 2)
                    begin
                        // long enough for bit 8 of the horizontal counter to change
                        repeat ($urandom_range(256, 300)) send_op(sfpg_pkg::MODE_HSTEP);
                        long_scrolls++;
                    end
                end
                18:
                begin
                    if (!calm)
                    begin
                        hold_request = 1'b1;
                        burst        = 1'b1;
                        holds++;
                    end
                    scan_run(48);
                    burst        = 1'b0;
                end
                19:
                begin
                    wait_results_done();
                end
                default:
                begin
                    scan_run(48);
                end
            endcase
        end

        wait_results_done();
        repeat (16) @(negedge clk);
        $display("run covered %0d result transfers, %0d of them star pixels", result_count,
                 star_count);
        $display("star rom rows loaded: %0d, long scroll bursts: %0d, output holds: %0d",
                 ready_rows.size(), long_scrolls, holds);
        if (fail_count == 0 && pending_results == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/sfpg_pkg.sv
src/sfpg_front.sv
src/sfpg_queue.sv
src/sfpg_back.sv
src/starfield_pixel_generator.sv
bench/starfield_pixel_checker.sv
bench/starfield_pixel_generator_tb.sv
